/* rtl/core/i2c_master_transfer_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// i2c master transfer sequencer assertion macros
// shared concurrent assertion forms used at the top level
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_IMP(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NXT(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

/* rtl/core/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// types, register codes and result expansion shared by the sequencer
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int MAX_TRANSFER_LENGTH_DEF = 255;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDR    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSFER_LEN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MESSAGE_INDEX = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MESSAGE_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_MODE     = 3'd4;

   // controller register offsets
   localparam logic [5:0] REG_SCR   = 6'h00;
   localparam logic [5:0] REG_MCR   = 6'h04;
   localparam logic [5:0] REG_SSR   = 6'h08;
   localparam logic [5:0] REG_MSR   = 6'h0C;
   localparam logic [5:0] REG_SIER  = 6'h10;
   localparam logic [5:0] REG_MIER  = 6'h14;
   localparam logic [5:0] REG_CCR   = 6'h18;
   localparam logic [5:0] REG_SAR   = 6'h1C;
   localparam logic [5:0] REG_MAR   = 6'h20;
   localparam logic [5:0] REG_DATA  = 6'h24;
   localparam logic [5:0] REG_FBSCR = 6'h38;

   localparam logic [7:0] MCR_RESET       = 8'h80;
   localparam logic [7:0] MCR_START       = 8'h89;
   localparam logic [7:0] MCR_DATA        = 8'h88;
   localparam logic [7:0] MCR_STOP        = 8'h8A;
   localparam logic [7:0] ACK_SEND        = 8'h76;
   localparam logic [7:0] ACK_RECV        = 8'h7C;
   localparam logic [7:0] IEN_SEND        = 8'h79;
   localparam logic [7:0] IEN_RECV        = 8'h73;
   localparam logic [7:0] FIRST_BIT_DELAY = 8'h0F;
   localparam logic [7:0] SCR_INIT        = 8'h08;
   localparam logic [7:0] CCR_STANDARD    = 8'hAE;
   localparam logic [7:0] CCR_FAST        = 8'h1E;

   localparam int ST_NACK_BIT = 6;
   localparam int ST_ARB_BIT  = 5;
   localparam int ST_STOP_BIT = 4;

   localparam logic [4:0] SETUP_STEPS = 5'd10;

   typedef enum logic {
      REQ_START  = 1'b0,
      REQ_STATUS = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      OUT_CONTINUE = 3'd0,
      OUT_DONE     = 3'd1,
      OUT_ARB_LOST = 3'd2,
      OUT_NACK     = 3'd3,
      OUT_INVALID  = 3'd4,
      OUT_BUSY     = 3'd5
   } outcome_type;

   typedef enum logic [2:0] {
      CMD_REFUSE    = 3'd0,
      CMD_START     = 3'd1,
      CMD_HALT      = 3'd2,
      CMD_SEND_STOP = 3'd3,
      CMD_SEND_DATA = 3'd4,
      CMD_RECV      = 3'd5
   } cmd_kind_type;

   typedef enum logic [1:0] {
      MCR_SEL_NONE = 2'd0,
      MCR_SEL_DATA = 2'd1,
      MCR_SEL_STOP = 2'd2
   } mcr_sel_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] master_status;
      logic [7:0] received_byte;
      logic [7:0] next_send_byte;
      logic       bus_busy;
   } req_type;

   typedef struct packed {
      logic        has_write;
      logic [5:0]  register_offset;
      logic [7:0]  write_value;
      logic        byte_taken;
      logic        read_valid;
      logic [7:0]  read_data;
      outcome_type outcome;
      logic        last;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      outcome_type  outcome;
      logic         setup;
      logic         fast;
      logic         rd;
      mcr_sel_type  mcr_sel;
      logic [7:0]   data;
      logic [7:0]   msr_value;
      logic         stored;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   function automatic rsp_type wr_rsp(input logic [5:0] off, input logic [7:0] val);
      rsp_type r;
      r = '0;
      r.has_write       = 1'b1;
      r.register_offset = off;
      r.write_value     = val;
      return r;
   endfunction

   // one result of a command, picked by its step number
   function automatic rsp_type cmd_result(input cmd_type cmd, input logic [3:0] step);
      rsp_type    r;
      logic [4:0] idx;
      logic [4:0] sub;
      r   = '0;
      idx = cmd.setup ? {1'b0, step} : ({1'b0, step} + SETUP_STEPS);
      sub = (cmd.mcr_sel != MCR_SEL_NONE) ? {1'b0, step} : ({1'b0, step} + 5'd1);
      unique case (cmd.kind)
         CMD_REFUSE: begin
            r.last = 1'b1;
         end
         CMD_START: begin
            unique case (idx)
               5'd0:    r = wr_rsp(REG_SIER, 8'h00);
               5'd1:    r = wr_rsp(REG_SCR, SCR_INIT);
               5'd2:    r = wr_rsp(REG_SAR, 8'h00);
               5'd3:    r = wr_rsp(REG_SSR, 8'h00);
               5'd4:    r = wr_rsp(REG_MIER, 8'h00);
               5'd5:    r = wr_rsp(REG_MCR, MCR_RESET);
               5'd6:    r = wr_rsp(REG_MAR, 8'h00);
               5'd7:    r = wr_rsp(REG_MSR, 8'h00);
               5'd8:    r = wr_rsp(REG_CCR, cmd.fast ? CCR_FAST : CCR_STANDARD);
               5'd9:    r = wr_rsp(REG_FBSCR, FIRST_BIT_DELAY);
               5'd10:   r = wr_rsp(REG_MAR, cmd.data);
               5'd11:   r = wr_rsp(REG_MSR, 8'h00);
               5'd12:   r = wr_rsp(REG_MCR, MCR_START);
               5'd13: begin
                  r      = wr_rsp(REG_MIER, cmd.rd ? IEN_RECV : IEN_SEND);
                  r.last = 1'b1;
               end
               default: r.last = 1'b1;
            endcase
         end
         CMD_HALT, CMD_SEND_STOP: begin
            if (step == 4'd0) begin
               r = (cmd.kind == CMD_HALT) ? wr_rsp(REG_MIER, 8'h00)
                                          : wr_rsp(REG_MCR, MCR_STOP);
            end else begin
               r      = wr_rsp(REG_MSR, 8'h00);
               r.last = 1'b1;
            end
         end
         CMD_SEND_DATA: begin
            unique case (sub)
               5'd0: r = wr_rsp(REG_MCR, MCR_DATA);
               5'd1: begin
                  r            = wr_rsp(REG_DATA, cmd.data);
                  r.byte_taken = 1'b1;
               end
               default: begin
                  r      = wr_rsp(REG_MSR, ACK_SEND);
                  r.last = 1'b1;
               end
            endcase
         end
         CMD_RECV: begin
            if (sub == 5'd0) begin
               r = wr_rsp(REG_MCR, (cmd.mcr_sel == MCR_SEL_STOP) ? MCR_STOP : MCR_DATA);
            end else begin
               r            = wr_rsp(REG_MSR, cmd.msr_value);
               r.read_valid = cmd.stored;
               r.read_data  = cmd.stored ? cmd.data : 8'h00;
               r.last       = 1'b1;
            end
         end
         default: begin
            r.last = 1'b1;
         end
      endcase
      r.outcome = cmd.outcome;
      return r;
   endfunction

endpackage

/* rtl/core/i2cm_front.sv */
// ----------------------------------------------------------------------------
// i2cm_front
// configuration registers, transfer state and request classification
// ----------------------------------------------------------------------------
module i2cm_front #(
   parameter int MAX_TRANSFER_LENGTH = i2cm_pkg::MAX_TRANSFER_LENGTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               accept,
   input  i2cm_pkg::req_type                  req_data,
   output i2cm_pkg::cmd_type                  cmd
);
   import i2cm_pkg::*;

   // the length register is 8 bits, so the cap never exceeds 255
   localparam int         LEN_CAP   = (MAX_TRANSFER_LENGTH > 255) ? 255 : MAX_TRANSFER_LENGTH;
   localparam logic [7:0] LEN_CAP_B = LEN_CAP[7:0];

   logic [7:0] slave_addr_ff;
   logic [7:0] transfer_len_ff;
   logic [3:0] msg_index_ff;
   logic [3:0] msg_count_ff;
   logic       fast_mode_ff;

   logic [8:0] byte_pos_ff,    byte_pos_in;
   logic       addr_pending_ff, addr_pending_in;

   logic       rd;
   logic [7:0] len;
   logic [8:0] len9;
   logic [9:0] pos_p1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff   <= 8'h00;
         transfer_len_ff <= 8'h00;
         msg_index_ff    <= 4'd0;
         msg_count_ff    <= 4'd1;
         fast_mode_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SLAVE_ADDR:    slave_addr_ff   <= csr_write_data;
            CSR_TRANSFER_LEN:  transfer_len_ff <= csr_write_data;
            CSR_MESSAGE_INDEX: msg_index_ff    <= csr_write_data[3:0];
            CSR_MESSAGE_COUNT: msg_count_ff    <= csr_write_data[3:0];
            CSR_FAST_MODE:     fast_mode_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rd     = slave_addr_ff[0];
      len    = (transfer_len_ff > LEN_CAP_B) ? LEN_CAP_B : transfer_len_ff;
      len9   = {1'b0, len};
      pos_p1 = {1'b0, byte_pos_ff} + 10'd1;

      byte_pos_in     = byte_pos_ff;
      addr_pending_in = addr_pending_ff;

      cmd           = '0;
      cmd.kind      = CMD_REFUSE;
      cmd.outcome   = OUT_CONTINUE;
      cmd.mcr_sel   = MCR_SEL_NONE;
      cmd.rd        = rd;
      cmd.fast      = fast_mode_ff;

      if (req_data.kind == REQ_START) begin
         byte_pos_in     = 9'd0;
         addr_pending_in = rd;
         if (msg_index_ff >= msg_count_ff) begin
            cmd.outcome = OUT_INVALID;
         end else if (msg_index_ff == 4'd0 && req_data.bus_busy) begin
            cmd.outcome = OUT_BUSY;
         end else begin
            cmd.kind  = CMD_START;
            cmd.setup = (msg_index_ff == 4'd0);
            cmd.data  = slave_addr_ff;
         end
      end else if (req_data.master_status[ST_ARB_BIT] || req_data.master_status[ST_NACK_BIT]
                   || req_data.master_status[ST_STOP_BIT]) begin
         cmd.kind = CMD_HALT;
         priority if (req_data.master_status[ST_ARB_BIT]) cmd.outcome = OUT_ARB_LOST;
         else if (req_data.master_status[ST_NACK_BIT])     cmd.outcome = OUT_NACK;
         else                                              cmd.outcome = OUT_DONE;
      end else if (!rd) begin
         if (byte_pos_ff >= len9) begin
            cmd.kind = CMD_SEND_STOP;
         end else begin
            cmd.kind    = CMD_SEND_DATA;
            cmd.mcr_sel = (byte_pos_ff == 9'd0) ? MCR_SEL_DATA : MCR_SEL_NONE;
            cmd.data    = req_data.next_send_byte;
            byte_pos_in = pos_p1[8:0];
         end
      end else begin
         cmd.kind = CMD_RECV;
         cmd.data = req_data.received_byte;
         // stop goes out ahead of the last byte
         if (len == 8'd1 || (len > 8'd1 && pos_p1 == {2'b00, len})) begin
            cmd.mcr_sel = MCR_SEL_STOP;
         end else if (addr_pending_ff) begin
            cmd.mcr_sel = MCR_SEL_DATA;
         end
         if (addr_pending_ff) begin
            addr_pending_in = 1'b0;
         end else if (byte_pos_ff < len9) begin
            cmd.stored  = 1'b1;
            byte_pos_in = pos_p1[8:0];
         end
         cmd.msr_value = (byte_pos_in < len9) ? ACK_RECV : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff     <= 9'd0;
         addr_pending_ff <= 1'b0;
      end else if (accept) begin
         byte_pos_ff     <= byte_pos_in;
         addr_pending_ff <= addr_pending_in;
      end
   end

endmodule

/* rtl/core/i2cm_cmd_queue.sv */
// ----------------------------------------------------------------------------
// i2cm_cmd_queue
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module i2cm_cmd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_cmd,
   input  i2cm_pkg::cmd_type           cmd_in,
   input  logic                        pop_cmd,
   output i2cm_pkg::cmd_type           cmd_head,
   output i2cm_pkg::queue_status_type  status
);
   import i2cm_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_cmd;
      rd_ptr_in = rd_ptr_ff ^ pop_cmd;
      count_in  = count_ff + {1'b0, push_cmd} - {1'b0, pop_cmd};
      cmd_head  = entry_ff[rd_ptr_ff];
      status.not_empty = (count_ff != 2'd0);
      status.full      = (count_ff == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (push_cmd) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/i2cm_back.sv */
// ----------------------------------------------------------------------------
// i2cm_back
// expands each command into its register writes, one result per cycle while the output slot is free or taken
// ----------------------------------------------------------------------------
module i2cm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  i2cm_pkg::cmd_type           cmd_head,
   input  i2cm_pkg::queue_status_type  q_status,
   output logic                        pop_cmd,
   input  logic                        pop,
   output logic                        empty,
   output i2cm_pkg::rsp_type           rsp_data
);
   import i2cm_pkg::*;

   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    next_rsp;
   logic       load;

   always_comb begin
      next_rsp     = cmd_result(cmd_head, step_ff);
      // the output slot refills in the same cycle it is taken
      load         = q_status.not_empty && (!rsp_valid_ff || pop);
      pop_cmd      = load && next_rsp.last;
      step_in      = step_ff;
      if (load) begin
         step_in = next_rsp.last ? 4'd0 : (step_ff + 4'd1);
      end
      rsp_valid_in = load || (rsp_valid_ff && !pop);
      empty        = !rsp_valid_ff;
      rsp_data     = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= next_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/core/i2c_master_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// interrupt-driven i2c master sequencer, requests in, register writes out
// ----------------------------------------------------------------------------
// A request is taken whenever full is low; the front classifies it, updates
// the byte position and places one command in a two-deep queue. The back
// turns each command into its results at one result per cycle while the
// output slot is free or being popped: 14 results for a start of the first
// message, 4 for a later start, 1 to 3 for a status event and 1 for a
// refused start. The back's expansion and the single output register set
// the pace; a result waiting on pop stops new requests only once the
// queue holds two commands.
module i2c_master_transfer_sequencer #(
   parameter int MAX_TRANSFER_LENGTH = i2cm_pkg::MAX_TRANSFER_LENGTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               push,
   output logic                               full,
   input  i2cm_pkg::req_type                  req_data,
   output logic                               empty,
   input  logic                               pop,
   output i2cm_pkg::rsp_type                  rsp_data
);
   import i2cm_pkg::*;

`include "i2c_master_transfer_sequencer_assert.svh"

   cmd_type          front_cmd;
   cmd_type          cmd_head;
   queue_status_type q_status;
   logic             accept;
   logic             cmd_pop;

   assign full   = q_status.full;
   assign accept = push && !q_status.full;

   i2cm_front #(
      .MAX_TRANSFER_LENGTH (MAX_TRANSFER_LENGTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_data         (req_data),
      .cmd              (front_cmd)
   );

   i2cm_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_cmd (accept),
      .cmd_in   (front_cmd),
      .pop_cmd  (cmd_pop),
      .cmd_head (cmd_head),
      .status   (q_status)
   );

   i2cm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_head (cmd_head),
      .q_status (q_status),
      .pop_cmd  (cmd_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

   `I2CM_ASSERT_IMP(a_no_pop_when_empty, clock, reset, cmd_pop, q_status.not_empty,
                    "command popped from empty queue")
   `I2CM_ASSERT_NXT(a_drain_when_idle, clock, reset, !empty && pop && !q_status.not_empty,
                    empty, "result appeared with no command")
   `I2CM_ASSERT_IMP(a_refusal_single, clock, reset,
                    !empty && (rsp_data.outcome == OUT_INVALID || rsp_data.outcome == OUT_BUSY),
                    rsp_data.last && !rsp_data.has_write, "refused request gave more than one result")

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// i2c master transfer sequencer testbench
// requests of both kinds go in through the request queue; every register
// write that comes out is checked against an in-bench model of the sequencer
// state, over directed cases and randomized send/receive sequences
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cm_pkg::*;

   localparam int MAX_LEN     = MAX_TRANSFER_LENGTH_DEF;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 4;
   localparam int RANDOM_ITEMS = 480;

   localparam logic [6:0] STAT_NACK     = 7'b1 << ST_NACK_BIT;
   localparam logic [6:0] STAT_ARB      = 7'b1 << ST_ARB_BIT;
   localparam logic [6:0] STAT_STOP     = 7'b1 << ST_STOP_BIT;
   localparam logic [6:0] STAT_TX_EMPTY = 7'h08;
   localparam logic [6:0] STAT_SENT     = 7'h04;
   localparam logic [6:0] STAT_RECEIVED = 7'h02;

   // tracks the sequencer state and holds the register writes still due
   class i2c_transfer_scoreboard;
      logic [7:0] addr_byte;
      logic [7:0] xfer_len;
      logic [3:0] msg_index;
      logic [3:0] msg_count;
      logic       fast;
      logic [8:0] byte_pos;
      logic       addr_pending;
      int         len_cap;
      rsp_type    step_writes[$];
      rsp_type    due_writes[$];
      int         errors;
      int         requests_seen;
      int         results_checked;
      int         setup_starts;
      int         short_starts;
      int         refused;
      int         bytes_sent;
      int         bytes_stored;
      int         halts;

      function new(int cap);
         len_cap         = cap;
         addr_byte       = '0;
         xfer_len        = '0;
         msg_index       = '0;
         msg_count       = 4'd1;
         fast            = 1'b0;
         byte_pos        = '0;
         addr_pending    = 1'b0;
         errors          = 0;
         requests_seen   = 0;
         results_checked = 0;
         setup_starts    = 0;
         short_starts    = 0;
         refused         = 0;
         bytes_sent      = 0;
         bytes_stored    = 0;
         halts           = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
         case (idx)
            CSR_SLAVE_ADDR:    addr_byte = val;
            CSR_TRANSFER_LEN:  xfer_len  = val;
            CSR_MESSAGE_INDEX: msg_index = val[3:0];
            CSR_MESSAGE_COUNT: msg_count = val[3:0];
            CSR_FAST_MODE:     fast      = val[0];
            default: ;
         endcase
      endfunction

      function void add_write(logic [5:0] off, logic [7:0] val, logic taken = 1'b0);
         rsp_type w;
         w                 = '0;
         w.has_write       = 1'b1;
         w.register_offset = off;
         w.write_value     = val;
         w.byte_taken      = taken;
         step_writes.push_back(w);
      endfunction

      function void add_blank();
         rsp_type w;
         w = '0;
         step_writes.push_back(w);
      endfunction

      function void note_request(req_type r);
         logic        rd;
         int          len;
         int          pos;
         logic        stored;
         outcome_type oc;
         rd     = addr_byte[0];
         len    = (int'(xfer_len) > len_cap) ? len_cap : int'(xfer_len);
         oc     = OUT_CONTINUE;
         stored = 1'b0;
         step_writes.delete();
         requests_seen++;
         if (r.kind == REQ_START) begin
            byte_pos     = '0;
            addr_pending = rd;
            if (msg_index >= msg_count) begin
               oc = OUT_INVALID;
               add_blank();
               refused++;
            end else if (msg_index == 4'd0 && r.bus_busy) begin
               oc = OUT_BUSY;
               add_blank();
               refused++;
            end else begin
               if (msg_index == 4'd0) begin
                  add_write(REG_SIER, 8'h00);
                  add_write(REG_SCR, SCR_INIT);
                  add_write(REG_SAR, 8'h00);
                  add_write(REG_SSR, 8'h00);
                  add_write(REG_MIER, 8'h00);
                  add_write(REG_MCR, MCR_RESET);
                  add_write(REG_MAR, 8'h00);
                  add_write(REG_MSR, 8'h00);
                  add_write(REG_CCR, fast ? CCR_FAST : CCR_STANDARD);
                  add_write(REG_FBSCR, FIRST_BIT_DELAY);
                  setup_starts++;
               end else begin
                  short_starts++;
               end
               add_write(REG_MAR, addr_byte);
               add_write(REG_MSR, 8'h00);
               add_write(REG_MCR, MCR_START);
               add_write(REG_MIER, rd ? IEN_RECV : IEN_SEND);
            end
         end else if (r.master_status[ST_ARB_BIT] || r.master_status[ST_NACK_BIT] ||
                      r.master_status[ST_STOP_BIT]) begin
            // arbitration loss wins over nack, nack over stop
            if (r.master_status[ST_ARB_BIT])
               oc = OUT_ARB_LOST;
            else if (r.master_status[ST_NACK_BIT])
               oc = OUT_NACK;
            else
               oc = OUT_DONE;
            add_write(REG_MIER, 8'h00);
            add_write(REG_MSR, 8'h00);
            halts++;
         end else if (!rd) begin
            pos = int'(byte_pos);
            // a position at or past the length means no data is left
            if (pos >= len) begin
               add_write(REG_MCR, MCR_STOP);
               add_write(REG_MSR, 8'h00);
            end else begin
               if (pos == 0)
                  add_write(REG_MCR, MCR_DATA);
               add_write(REG_DATA, r.next_send_byte, 1'b1);
               byte_pos = byte_pos + 9'd1;
               add_write(REG_MSR, ACK_SEND);
               bytes_sent++;
            end
         end else begin
            pos = int'(byte_pos);
            if (len == 1 || (len > 1 && pos + 1 == len))
               add_write(REG_MCR, MCR_STOP);
            else if (addr_pending)
               add_write(REG_MCR, MCR_DATA);
            // the first receive step only finishes the address phase
            if (addr_pending) begin
               addr_pending = 1'b0;
            end else if (pos < len) begin
               stored   = 1'b1;
               byte_pos = byte_pos + 9'd1;
            end
            add_write(REG_MSR, (int'(byte_pos) < len) ? ACK_RECV : 8'h00);
            if (stored) begin
               step_writes[$].read_valid = 1'b1;
               step_writes[$].read_data  = r.received_byte;
               bytes_stored++;
            end
         end
         foreach (step_writes[k]) begin
            step_writes[k].outcome = oc;
            step_writes[k].last    = (k == step_writes.size() - 1);
            due_writes.push_back(step_writes[k]);
         end
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         errors++;
         if (errors <= 10) begin
            $display("%s at result %0d", what, results_checked);
            $display("  expected wr=%0b off=%h val=%h taken=%0b rv=%0b rd=%h oc=%0d last=%0b",
                     want.has_write, want.register_offset, want.write_value,
                     want.byte_taken, want.read_valid, want.read_data, want.outcome,
                     want.last);
            $display("  actual   wr=%0b off=%h val=%h taken=%0b rv=%0b rd=%h oc=%0d last=%0b",
                     got.has_write, got.register_offset, got.write_value,
                     got.byte_taken, got.read_valid, got.read_data, got.outcome, got.last);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_checked++;
         if (due_writes.size() == 0) begin
            want = '0;
            report("result with nothing expected", want, got);
            return;
         end
         want = due_writes.pop_front();
         if (got.has_write !== want.has_write ||
             got.register_offset !== want.register_offset ||
             got.write_value !== want.write_value ||
             got.byte_taken !== want.byte_taken ||
             got.read_valid !== want.read_valid ||
             got.read_data !== want.read_data ||
             got.outcome !== want.outcome ||
             got.last !== want.last)
            report("mismatch", want, got);
      endfunction

      function int outstanding();
         return due_writes.size();
      endfunction

      function void close_out();
         if (due_writes.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", due_writes.size());
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   push;
   logic                   full;
   req_type                req_data;
   logic                   empty;
   logic                   pop;
   rsp_type                rsp_data;

   i2c_transfer_scoreboard sb;
   int   items_sent;
   int   settings_used;
   int   quiet_cycles;
   int   rsp_hold;
   logic req_idle_on;
   logic rsp_idle_on;

   i2c_master_transfer_sequencer #(
      .MAX_TRANSFER_LENGTH(MAX_LEN)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .full             (full),
      .req_data         (req_data),
      .empty            (empty),
      .pop              (pop),
      .rsp_data         (rsp_data)
   );

   always #2 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(1, 2);
      else if (r < 90)
         return $urandom_range(3, 8);
      return $urandom_range(15, 60);
   endfunction

   // result side: pop with random stalls
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (rsp_hold > 0) begin
         pop <= 1'b0;
         rsp_hold--;
      end else begin
         pop <= 1'b1;
         if (rsp_idle_on && $urandom_range(0, 99) < 30)
            rsp_hold = idle_span();
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full)
            sb.note_request(req_data);
         if (pop && !empty)
            sb.check_result(rsp_data);
         if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("no handshake for %0d cycles", QUIET_LIMIT);
               $display("simulation failed");
               $finish;
            end
         end
      end
   end

   task automatic send_request(req_kind_type kind, logic [6:0] st, logic [7:0] rx,
                               logic [7:0] tx, logic busy);
      req_type r;
      int      gap;
      r                = '0;
      r.kind           = kind;
      r.master_status  = st;
      r.received_byte  = rx;
      r.next_send_byte = tx;
      r.bus_busy       = busy;
      gap = (req_idle_on && $urandom_range(0, 1) == 1) ? idle_span() : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!full)
            break;
      end
      items_sent++;
   endtask

   task automatic send_start(logic busy);
      send_request(REQ_START, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), busy);
   endtask

   task automatic send_status(logic [6:0] st, logic [7:0] rx, logic [7:0] tx);
      send_request(REQ_STATUS, st, rx, tx, 1'($urandom_range(0, 1)));
   endtask

   // hold off new requests until every expected write is out
   task automatic wait_drained();
      push <= 1'b0;
      // the monitor logs the last accepted request at that same edge
      @(negedge clock);
      while (sb.outstanding() != 0)
         @(negedge clock);
      @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      sb.set_register(idx, val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pick_settings();
      int         r;
      logic [3:0] cnt;
      logic [3:0] idx;
      r = $urandom_range(0, 99);
      write_csr(CSR_SLAVE_ADDR, (r < 10) ? 8'h00 : (r < 20) ? 8'hFF :
                                8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 70)
         write_csr(CSR_TRANSFER_LEN, 8'($urandom_range(0, 6)));
      else if (r < 90)
         write_csr(CSR_TRANSFER_LEN, 8'($urandom_range(7, 20)));
      else
         write_csr(CSR_TRANSFER_LEN, ($urandom_range(0, 1) == 1) ? 8'hFF :
                                     8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 60) begin
         idx = 4'd0;
         cnt = 4'($urandom_range(1, 15));
      end else if (r < 85) begin
         cnt = 4'($urandom_range(2, 15));
         idx = 4'($urandom_range(1, cnt - 1));
      end else if (r < 95) begin
         idx = 4'($urandom_range(0, 15));
         cnt = 4'($urandom_range(0, idx));
      end else begin
         idx = 4'd15;
         cnt = 4'd15;
      end
      write_csr(CSR_MESSAGE_INDEX, {4'd0, idx});
      write_csr(CSR_MESSAGE_COUNT, {4'd0, cnt});
      write_csr(CSR_FAST_MODE, 8'($urandom_range(0, 1)));
      settings_used++;
   endtask

   // one message: usually a start, a run of mostly ordinary events, usually a closing stop
   task automatic run_message();
      int n;
      if ($urandom_range(0, 99) >= 10)
         send_start($urandom_range(0, 99) < 15);
      n = $urandom_range(1, 30);
      repeat (n) begin
         if ($urandom_range(0, 99) < 85)
            send_status(7'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
         else if ($urandom_range(0, 99) < 80)
            send_status(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
         else
            send_start(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 99) < 70)
         send_status(STAT_STOP | 7'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      push             = 1'b0;
      req_data         = '0;
      pop              = 1'b0;
      rsp_hold         = 0;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      items_sent       = 0;
      settings_used    = 1;
      quiet_cycles     = 0;
      sb = new(MAX_LEN);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: write direction, no data, first of one message
      send_status(7'h00, 8'h00, 8'h00);
      send_start(1'b1);
      send_start(1'b0);
      send_status(STAT_TX_EMPTY, 8'hFF, 8'hFF);
      wait_drained();

      // two byte write in fast mode
      write_csr(CSR_SLAVE_ADDR, 8'hA4);
      write_csr(CSR_TRANSFER_LEN, 8'd2);
      write_csr(CSR_FAST_MODE, 8'd1);
      send_start(1'b0);
      send_status(STAT_TX_EMPTY, 8'h00, 8'hFF);
      send_status(STAT_SENT, 8'hFF, 8'h00);
      send_status(STAT_SENT | STAT_TX_EMPTY, 8'h00, 8'h5A);
      send_status(STAT_STOP, 8'h00, 8'h00);
      wait_drained();

      // length cut below the position already sent
      write_csr(CSR_TRANSFER_LEN, 8'd1);
      send_status(STAT_SENT, 8'h00, 8'hC3);
      wait_drained();

      // three byte read as a later message; busy flag has no effect there
      write_csr(CSR_SLAVE_ADDR, 8'hFF);
      write_csr(CSR_TRANSFER_LEN, 8'd3);
      write_csr(CSR_MESSAGE_INDEX, 8'd1);
      write_csr(CSR_MESSAGE_COUNT, 8'd2);
      send_start(1'b1);
      send_status(STAT_RECEIVED, 8'h11, 8'h00);
      send_status(STAT_RECEIVED, 8'hFF, 8'h00);
      send_status(STAT_RECEIVED, 8'h00, 8'h00);
      send_status(STAT_RECEIVED, 8'h80, 8'h00);
      send_status(STAT_RECEIVED, 8'h01, 8'h00);
      send_status(STAT_ARB | STAT_NACK | STAT_STOP, 8'h00, 8'h00);
      send_status(STAT_NACK | STAT_STOP, 8'h00, 8'h00);
      wait_drained();

      // refused: index equal to count, then count of zero
      write_csr(CSR_MESSAGE_INDEX, 8'd15);
      write_csr(CSR_MESSAGE_COUNT, 8'd15);
      send_start(1'b0);
      wait_drained();
      write_csr(CSR_MESSAGE_INDEX, 8'd0);
      write_csr(CSR_MESSAGE_COUNT, 8'd0);
      send_start(1'b0);
      wait_drained();

      // single byte read, then a read with no data
      write_csr(CSR_TRANSFER_LEN, 8'd1);
      write_csr(CSR_MESSAGE_INDEX, 8'd2);
      write_csr(CSR_MESSAGE_COUNT, 8'd15);
      send_start(1'b0);
      send_status(STAT_RECEIVED, 8'hAA, 8'h00);
      send_status(STAT_RECEIVED, 8'h55, 8'h00);
      wait_drained();
      write_csr(CSR_TRANSFER_LEN, 8'd0);
      send_start(1'b0);
      send_status(STAT_RECEIVED, 8'h3C, 8'h00);
      send_status(STAT_RECEIVED, 8'hC3, 8'h00);
      wait_drained();

      while (items_sent < RANDOM_ITEMS) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         pick_settings();
         run_message();
         if ($urandom_range(0, 1) == 1)
            run_message();
         wait_drained();
      end

      sb.close_out();
      $display("run covered %0d requests, %0d results, %0d register settings",
               sb.requests_seen, sb.results_checked, settings_used);
      $display("%0d setups, %0d later starts, %0d refused, %0d sent, %0d stored, %0d halts",
               sb.setup_starts, sb.short_starts, sb.refused, sb.bytes_sent,
               sb.bytes_stored, sb.halts);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
